// ===== rtl/htpc_pkg.sv =====
package htpc_pkg;

   // Fixed vertex layout: x, y, z, w, u, v.
   localparam int NUM_ATTR    = 6;
   localparam int TRI_VERTS   = 3;
   localparam int MAX_RESULTS = 6;
   localparam int W_INDEX     = 3;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_PLANE_AXIS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_NEAR_SIDE  = 2'd1;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int ATTR_CNT_BITS = 3;
   localparam int EMIT_CNT_BITS = 3;

   typedef logic [1:0] vidx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_PLAN,
      ST_CUT_INIT,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      SRC_V0,
      SRC_V1,
      SRC_V2,
      SRC_CUT_A,
      SRC_CUT_B
   } src_type;

   typedef struct packed {
      logic     load_vert;
      vidx_type slot;
      logic     dist_load;
      logic     cut_init;
      vidx_type sel_in;
      vidx_type sel_out;
      logic     div_step;
      logic     mul_step;
      logic     acc_step;
      logic     acc_to_b;
      logic     out_load;
      src_type  src;
      logic     out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [TRI_VERTS-1:0] in_mask;
      logic                 out_busy;
   } dp_stat_type;

endpackage

// ===== rtl/htpc_if.sv =====
// Input vertex channel.
interface htpc_req_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] pos_x;
   logic signed [W-1:0] pos_y;
   logic signed [W-1:0] pos_z;
   logic signed [W-1:0] pos_w;
   logic signed [W-1:0] tex_u;
   logic signed [W-1:0] tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, pos_w, tex_u, tex_v, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, pos_w, tex_u, tex_v, output ready);
endinterface

// Clipped vertex channel.
interface htpc_rsp_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] out_x;
   logic signed [W-1:0] out_y;
   logic signed [W-1:0] out_z;
   logic signed [W-1:0] out_w;
   logic signed [W-1:0] out_u;
   logic signed [W-1:0] out_v;
   logic                last_of_group;

   modport source (output valid, out_x, out_y, out_z, out_w, out_u, out_v, last_of_group,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, out_u, out_v, last_of_group,
                 output ready);
endinterface

// ===== rtl/homogeneous_triangle_plane_clipper.sv =====
// Channel   Direction  Beat contents
// req_bus   in         one clip-space vertex: pos_x, pos_y, pos_z, pos_w, tex_u, tex_v
// rsp_bus   out        one clipped vertex: out_x .. out_v, last_of_group
// csr_*     in         register write: plane_axis (index 0), near_side (index 1)
//
// The first two vertices of a triangle are only stored. The third starts
// processing: a distance state and a planning state, then for each new
// vertex a set-up state, a restoring divider (one quotient bit per cycle)
// and a shared multiplier that takes the attributes one at a time, then the
// output beats. Reset is synchronous and clears the vertex slot and config.
// An output stall holds the beat in its register and pauses emission.
module homogeneous_triangle_plane_clipper #(
   parameter int ATTR_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [htpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [htpc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   htpc_req_if.sink                            req_bus,
   htpc_rsp_if.source                          rsp_bus
);

   htpc_pkg::dp_cmd_type  cmd;
   htpc_pkg::dp_stat_type stat;
   logic signed [ATTR_BITS-1:0] attr_in [htpc_pkg::NUM_ATTR];
   logic signed [ATTR_BITS-1:0] out_attr [htpc_pkg::NUM_ATTR];

   assign attr_in[0] = req_bus.pos_x;
   assign attr_in[1] = req_bus.pos_y;
   assign attr_in[2] = req_bus.pos_z;
   assign attr_in[3] = req_bus.pos_w;
   assign attr_in[4] = req_bus.tex_u;
   assign attr_in[5] = req_bus.tex_v;

   assign rsp_bus.out_x = out_attr[0];
   assign rsp_bus.out_y = out_attr[1];
   assign rsp_bus.out_z = out_attr[2];
   assign rsp_bus.out_w = out_attr[3];
   assign rsp_bus.out_u = out_attr[4];
   assign rsp_bus.out_v = out_attr[5];

   htpc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   htpc_dp #(.ATTR_BITS(ATTR_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .attr_in   (attr_in),
      .out_attr  (out_attr),
      .out_last  (rsp_bus.last_of_group),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready)
   );

endmodule

// ===== rtl/htpc_dp.sv =====
module htpc_dp #(
   parameter int ATTR_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [htpc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [htpc_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  htpc_pkg::dp_cmd_type                   cmd,
   output htpc_pkg::dp_stat_type                  stat,
   input  logic signed [ATTR_BITS-1:0]            attr_in [htpc_pkg::NUM_ATTR],
   output logic signed [ATTR_BITS-1:0]            out_attr [htpc_pkg::NUM_ATTR],
   output logic                                   out_last,
   output logic                                   out_valid,
   input  logic                                   out_ready
);

   localparam int DW = ATTR_BITS + 1;            // distance
   localparam int NW = ATTR_BITS + 3;            // divider remainder and divisor
   localparam int PW = ATTR_BITS + 1 + FRAC_BITS; // lerp product
   localparam int RW = ATTR_BITS + 2;            // lerp sum
   localparam int NA = htpc_pkg::NUM_ATTR;

   typedef logic signed [ATTR_BITS-1:0] attr_type;
   typedef logic signed [DW-1:0]        dist_type;

   attr_type vert0_ff [NA];
   attr_type vert1_ff [NA];
   attr_type vert2_ff [NA];
   attr_type vi_ff [NA];
   attr_type vo_ff [NA];
   attr_type cut_a_ff [NA];
   attr_type cut_b_ff [NA];
   attr_type out_ff [NA];
   attr_type vin_sel [NA];
   attr_type vout_sel [NA];
   attr_type src_sel [NA];
   dist_type d_ff [htpc_pkg::TRI_VERTS];
   dist_type d_in_sel, d_out_sel;
   logic [1:0]           axis_ff;
   logic                 near_ff;
   logic [NW-1:0]        rem_ff, den_ff, rem_shift;
   logic [FRAC_BITS-1:0] t_ff;
   logic [PW-1:0]        prod_ff;
   logic                 neg_ff;
   logic                 out_last_ff, out_valid_ff;
   dist_type             diff;
   logic [DW-1:0]        mag;
   logic [PW:0]          prod_sum;
   logic [RW-1:0]        p_val, lerp_res;
   attr_type             lerp_new;

   // Signed distance of one vertex from the selected plane.
   function automatic dist_type dist_f(input attr_type cx, input attr_type cy,
                                       input attr_type cz, input attr_type cw,
                                       input logic [1:0] axis, input logic near);
      attr_type c;
      case (axis)
         htpc_pkg::AXIS_X: c = cx;
         htpc_pkg::AXIS_Y: c = cy;
         default:          c = cz;
      endcase
      if (near) begin
         dist_f = DW'(c) + DW'(cw);
      end else begin
         dist_f = DW'(cw) - DW'(c);
      end
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= htpc_pkg::AXIS_Z;
         near_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            htpc_pkg::CFG_PLANE_AXIS: axis_ff <= csr_wdata[1:0];
            htpc_pkg::CFG_NEAR_SIDE:  near_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Vertex capture and distances.
   always_ff @(posedge clock) begin
      if (cmd.load_vert) begin
         unique case (cmd.slot)
            2'd0:    vert0_ff <= attr_in;
            2'd1:    vert1_ff <= attr_in;
            default: vert2_ff <= attr_in;
         endcase
      end
      if (cmd.dist_load) begin
         d_ff[0] <= dist_f(vert0_ff[0], vert0_ff[1], vert0_ff[2],
                           vert0_ff[htpc_pkg::W_INDEX], axis_ff, near_ff);
         d_ff[1] <= dist_f(vert1_ff[0], vert1_ff[1], vert1_ff[2],
                           vert1_ff[htpc_pkg::W_INDEX], axis_ff, near_ff);
         d_ff[2] <= dist_f(vert2_ff[0], vert2_ff[1], vert2_ff[2],
                           vert2_ff[htpc_pkg::W_INDEX], axis_ff, near_ff);
      end
   end

   assign stat.in_mask = {d_ff[2] > 0, d_ff[1] > 0, d_ff[0] > 0};

   // Vertex selection for the cut under way.
   always_comb begin
      unique case (cmd.sel_in)
         2'd0:    begin vin_sel = vert0_ff; d_in_sel = d_ff[0]; end
         2'd1:    begin vin_sel = vert1_ff; d_in_sel = d_ff[1]; end
         default: begin vin_sel = vert2_ff; d_in_sel = d_ff[2]; end
      endcase
      unique case (cmd.sel_out)
         2'd0:    begin vout_sel = vert0_ff; d_out_sel = d_ff[0]; end
         2'd1:    begin vout_sel = vert1_ff; d_out_sel = d_ff[1]; end
         default: begin vout_sel = vert2_ff; d_out_sel = d_ff[2]; end
      endcase
   end

   // Restoring divider: t = dO / (dO - dI), one quotient bit a cycle.
   assign rem_shift = {rem_ff[NW-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.cut_init) begin
         vi_ff  <= vin_sel;
         vo_ff  <= vout_sel;
         rem_ff <= NW'(NW'(0) - NW'(d_out_sel));
         den_ff <= NW'(NW'(d_in_sel) - NW'(d_out_sel));
         t_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= den_ff) begin
            rem_ff <= rem_shift - den_ff;
            t_ff   <= {t_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            t_ff   <= {t_ff[FRAC_BITS-2:0], 1'b0};
         end
      end else if (cmd.acc_step) begin
         for (int k = 0; k < NA - 1; k++) begin
            vi_ff[k] <= vi_ff[k+1];
            vo_ff[k] <= vo_ff[k+1];
         end
      end
   end

   // Lerp, one attribute at a time: magnitude times t, then rounded add.
   assign diff     = DW'(vi_ff[0]) - DW'(vo_ff[0]);
   assign mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign prod_sum = (PW+1)'(prod_ff) + (neg_ff ? (PW+1)'((1 << FRAC_BITS) - 1) : '0);
   assign p_val    = prod_sum[PW:FRAC_BITS];
   assign lerp_res = neg_ff ? RW'(vo_ff[0]) - p_val : RW'(vo_ff[0]) + p_val;
   assign lerp_new = lerp_res[ATTR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         prod_ff <= PW'(mag) * PW'(t_ff);
         neg_ff  <= diff[DW-1];
      end
      if (cmd.acc_step) begin
         if (cmd.acc_to_b) begin
            for (int k = 0; k < NA - 1; k++) begin
               cut_b_ff[k] <= cut_b_ff[k+1];
            end
            cut_b_ff[NA-1] <= lerp_new;
         end else begin
            for (int k = 0; k < NA - 1; k++) begin
               cut_a_ff[k] <= cut_a_ff[k+1];
            end
            cut_a_ff[NA-1] <= lerp_new;
         end
      end
   end

   // Output register.
   always_comb begin
      unique case (cmd.src)
         htpc_pkg::SRC_V0:    src_sel = vert0_ff;
         htpc_pkg::SRC_V1:    src_sel = vert1_ff;
         htpc_pkg::SRC_V2:    src_sel = vert2_ff;
         htpc_pkg::SRC_CUT_A: src_sel = cut_a_ff;
         default:             src_sel = cut_b_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_ff      <= src_sel;
         out_last_ff <= cmd.out_last;
      end
   end

   assign out_attr      = out_ff;
   assign out_last      = out_last_ff;
   assign out_valid     = out_valid_ff;
   assign stat.out_busy = out_valid_ff && !out_ready;

   // The divisor is nonzero for every cut.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.cut_init |=> den_ff != '0)
      else $error("divisor zero after cut set-up");

   // The partial remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.cut_init || cmd.div_step) |=> rem_ff < den_ff)
      else $error("divider remainder out of range");

endmodule

// ===== rtl/htpc_ctrl.sv =====
module htpc_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output htpc_pkg::dp_cmd_type  cmd,
   input  htpc_pkg::dp_stat_type stat
);

   localparam int CW = $clog2(FRAC_BITS);

   htpc_pkg::state_type state_ff, state_in;
   htpc_pkg::vidx_type  slot_ff, slot_in;
   htpc_pkg::vidx_type  in_a_ff, in_a_in, out_a_ff, out_a_in;
   htpc_pkg::vidx_type  in_b_ff, in_b_in, out_b_ff, out_b_in;
   logic                all_in_ff, all_in_in, two_in_ff, two_in_in;
   logic                cut_sel_ff, cut_sel_in;
   logic [CW-1:0]       div_cnt_ff, div_cnt_in;
   logic [htpc_pkg::ATTR_CNT_BITS-1:0] attr_cnt_ff, attr_cnt_in;
   logic [htpc_pkg::EMIT_CNT_BITS-1:0] emit_cnt_ff, emit_cnt_in, emit_j;
   logic [htpc_pkg::EMIT_CNT_BITS-1:0] emit_total;
   logic [htpc_pkg::TRI_VERTS-1:0]     ins;
   logic [1:0]                         nin;

   function automatic htpc_pkg::src_type vsrc(input htpc_pkg::vidx_type idx);
      unique case (idx)
         2'd0:    vsrc = htpc_pkg::SRC_V0;
         2'd1:    vsrc = htpc_pkg::SRC_V1;
         default: vsrc = htpc_pkg::SRC_V2;
      endcase
   endfunction

   // State and sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= htpc_pkg::ST_IDLE;
         slot_ff     <= '0;
         cut_sel_ff  <= 1'b0;
         div_cnt_ff  <= '0;
         attr_cnt_ff <= '0;
         emit_cnt_ff <= '0;
         all_in_ff   <= 1'b0;
         two_in_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         slot_ff     <= slot_in;
         cut_sel_ff  <= cut_sel_in;
         div_cnt_ff  <= div_cnt_in;
         attr_cnt_ff <= attr_cnt_in;
         emit_cnt_ff <= emit_cnt_in;
         all_in_ff   <= all_in_in;
         two_in_ff   <= two_in_in;
      end
      in_a_ff  <= in_a_in;
      out_a_ff <= out_a_in;
      in_b_ff  <= in_b_in;
      out_b_ff <= out_b_in;
   end

   assign ins        = stat.in_mask;
   assign nin        = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
   assign emit_total = two_in_ff ? htpc_pkg::EMIT_CNT_BITS'(htpc_pkg::MAX_RESULTS)
                                 : htpc_pkg::EMIT_CNT_BITS'(htpc_pkg::TRI_VERTS);
   assign emit_j     = emit_cnt_ff - htpc_pkg::EMIT_CNT_BITS'(htpc_pkg::TRI_VERTS);

   // Next state and datapath commands.
   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      cut_sel_in  = cut_sel_ff;
      div_cnt_in  = div_cnt_ff;
      attr_cnt_in = attr_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      all_in_in   = all_in_ff;
      two_in_in   = two_in_ff;
      in_a_in     = in_a_ff;
      out_a_in    = out_a_ff;
      in_b_in     = in_b_ff;
      out_b_in    = out_b_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.src     = htpc_pkg::SRC_V0;
      cmd.sel_in  = cut_sel_ff ? in_b_ff : in_a_ff;
      cmd.sel_out = cut_sel_ff ? out_b_ff : out_a_ff;
      cmd.slot    = slot_ff;
      cmd.acc_to_b = cut_sel_ff;

      unique case (state_ff)
         htpc_pkg::ST_IDLE: begin
            // No beat is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_vert = 1'b1;
               if (slot_ff == 2'd2) begin
                  slot_in  = '0;
                  state_in = htpc_pkg::ST_DIST;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end
         end
         htpc_pkg::ST_DIST: begin
            cmd.dist_load = 1'b1;
            state_in      = htpc_pkg::ST_PLAN;
         end
         htpc_pkg::ST_PLAN: begin
            all_in_in   = (nin == 2'd3);
            two_in_in   = (nin == 2'd2);
            cut_sel_in  = 1'b0;
            attr_cnt_in = '0;
            emit_cnt_in = '0;
            if (nin == 2'd2) begin
               in_a_in  = ins[0] ? 2'd0 : 2'd1;
               in_b_in  = ins[2] ? 2'd2 : 2'd1;
               out_a_in = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
               out_b_in = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
            end else begin
               in_a_in  = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
               in_b_in  = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
               out_a_in = !ins[0] ? 2'd0 : 2'd1;
               out_b_in = !ins[2] ? 2'd2 : 2'd1;
            end
            if (nin == 2'd0) begin
               state_in = htpc_pkg::ST_IDLE;
            end else if (nin == 2'd3) begin
               state_in = htpc_pkg::ST_EMIT;
            end else begin
               state_in = htpc_pkg::ST_CUT_INIT;
            end
         end
         htpc_pkg::ST_CUT_INIT: begin
            cmd.cut_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = htpc_pkg::ST_DIV;
         end
         htpc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + CW'(1);
            if (div_cnt_ff == CW'(FRAC_BITS - 1)) begin
               state_in = htpc_pkg::ST_MUL;
            end
         end
         htpc_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = htpc_pkg::ST_ACC;
         end
         htpc_pkg::ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (attr_cnt_ff == htpc_pkg::ATTR_CNT_BITS'(htpc_pkg::NUM_ATTR - 1)) begin
               attr_cnt_in = '0;
               if (cut_sel_ff) begin
                  state_in = htpc_pkg::ST_EMIT;
               end else begin
                  cut_sel_in = 1'b1;
                  state_in   = htpc_pkg::ST_CUT_INIT;
               end
            end else begin
               attr_cnt_in = attr_cnt_ff + 1'b1;
               state_in    = htpc_pkg::ST_MUL;
            end
         end
         htpc_pkg::ST_EMIT: begin
            // Pick the source of output vertex emit_cnt_ff.
            if (all_in_ff) begin
               cmd.src = vsrc(emit_cnt_ff[1:0]);
            end else if (!two_in_ff) begin
               if (emit_cnt_ff[1:0] == in_a_ff) begin
                  cmd.src = vsrc(in_a_ff);
               end else if (emit_cnt_ff[1:0] == out_a_ff) begin
                  cmd.src = htpc_pkg::SRC_CUT_A;
               end else begin
                  cmd.src = htpc_pkg::SRC_CUT_B;
               end
            end else if (emit_cnt_ff < htpc_pkg::EMIT_CNT_BITS'(htpc_pkg::TRI_VERTS)) begin
               cmd.src = (emit_cnt_ff[1:0] == out_a_ff) ? htpc_pkg::SRC_CUT_A
                                                        : vsrc(emit_cnt_ff[1:0]);
            end else if (emit_j[1:0] == out_a_ff) begin
               cmd.src = htpc_pkg::SRC_CUT_B;
            end else if (emit_j[1:0] == in_a_ff) begin
               cmd.src = htpc_pkg::SRC_CUT_A;
            end else begin
               cmd.src = vsrc(in_b_ff);
            end
            cmd.out_last = (emit_cnt_ff == emit_total - 1'b1);
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               emit_cnt_in  = emit_cnt_ff + 1'b1;
               if (cmd.out_last) begin
                  state_in = htpc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = htpc_pkg::ST_IDLE;
      endcase
   end

   // A cut always runs from an inside vertex to an outside one.
   a_cut_sides: assert property (@(posedge clock) disable iff (reset)
      cmd.cut_init |-> (stat.in_mask[cmd.sel_in] && !stat.in_mask[cmd.sel_out]))
      else $error("cut set up between wrong vertices");

   // Emission never runs past six beats.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == htpc_pkg::ST_EMIT |-> emit_cnt_ff < emit_total)
      else $error("emission count out of range");

   // No beat is loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_busy)
      else $error("output beat overwritten");

endmodule
